// ===== hw/rtl/gptc_pkg.sv =====
// shared types, constants and the arctangent table for the pitch tilt compensation
`default_nettype none
package gptc_pkg;

	localparam int XY_W = 33;
	localparam int Z_W  = 32;
	localparam int ATAN_ENTRIES = 24;

	// register indexes on the config port
	typedef enum logic [0:0] {
		REG_YAW_OFFSET = 1'b0,
		REG_DEAD_ZONE  = 1'b1
	} reg_index_t;

	// cordic start vector x, gain of the infinite product in q2.30
	localparam logic signed [XY_W-1:0] CORDIC_GAIN = 33'sd652032874;

	// angles in centidegrees times 65536
	localparam logic signed [Z_W-1:0] HALF_TURN    = 32'sd1179648000;
	localparam logic signed [Z_W-1:0] QUARTER_TURN = 32'sd589824000;

	typedef struct packed {
		logic signed [XY_W-1:0] x;
		logic signed [XY_W-1:0] y;
		logic signed [Z_W-1:0]  z;
		logic                   neg;
		logic signed [15:0]     pitch;
		logic signed [15:0]     roll;
	} cordic_t;

	// atan(2^-i) in centidegrees times 65536
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] a;
		case (i)
			0:  a = 32'sd294912000;
			1:  a = 32'sd174096719;
			2:  a = 32'sd91987925;
			3:  a = 32'sd46694507;
			4:  a = 32'sd23437865;
			5:  a = 32'sd11730358;
			6:  a = 32'sd5866610;
			7:  a = 32'sd2933484;
			8:  a = 32'sd1466764;
			9:  a = 32'sd733385;
			10: a = 32'sd366693;
			11: a = 32'sd183346;
			12: a = 32'sd91673;
			13: a = 32'sd45837;
			14: a = 32'sd22918;
			15: a = 32'sd11459;
			16: a = 32'sd5730;
			17: a = 32'sd2865;
			18: a = 32'sd1432;
			19: a = 32'sd716;
			20: a = 32'sd358;
			21: a = 32'sd179;
			22: a = 32'sd90;
			23: a = 32'sd45;
			default: a = '0;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/gptc_prep.sv =====
// front end: dead zone, relative yaw angle, wrap to half a turn and quadrant fold
`default_nettype none
module gptc_prep #(
	parameter int ENCODER_BITS = 13
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     up_v,
	output logic                          up_rdy,
	input  wire logic signed [15:0]       chassis_pitch,
	input  wire logic signed [15:0]       chassis_roll,
	input  wire logic signed [15:0]       chassis_yaw,
	input  wire logic [ENCODER_BITS-1:0]  yaw_encoder,
	input  wire logic signed [15:0]       yaw_offset,
	input  wire logic [13:0]              dead_zone,
	output logic                          dn_v,
	input  wire logic                     dn_rdy,
	output logic signed [gptc_pkg::Z_W-1:0] dn_z,
	output logic                          dn_neg,
	output logic signed [15:0]            dn_pitch,
	output logic signed [15:0]            dn_roll
);

	localparam int SH = 16 - ENCODER_BITS;
	localparam int EP_W = ENCODER_BITS + 16;
	localparam logic signed [18:0] CD_TURN = 19'sd36000;
	localparam logic signed [16:0] CD_TURN17 = 17'sd36000;
	localparam logic signed [32:0] TURN33 = 33'sd2359296000;
	localparam logic signed [32:0] HALF33 = 33'sd1179648000;

	logic v_s1, v_s2, v_s3, v_s4;
	logic rdy1, rdy2, rdy3, rdy4;

	logic signed [15:0] pitch_s1, roll_s1, pitch_s2, roll_s2, pitch_s3, roll_s3;
	logic signed [16:0] ysum_s1;
	logic [ENCODER_BITS-1:0] enc_s1;
	logic [15:0] sr_s2;
	logic [31:0] a_s2;
	logic signed [31:0] zw_s3;
	logic signed [31:0] z_s4;
	logic neg_s4;
	logic signed [15:0] pitch_s4, roll_s4;

	logic signed [16:0] pe, re;
	logic [16:0] pmag, rmag;
	logic signed [18:0] ye, yred;
	logic [EP_W-1:0] ep;
	logic signed [32:0] z33, zwr;
	logic signed [31:0] zf;
	logic nf;

	assign rdy4 = !v_s4 || dn_rdy;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign up_rdy = rdy1;

	// stage 1: dead zone and chassis yaw plus offset
	always_comb begin
		pe = {chassis_pitch[15], chassis_pitch};
		re = {chassis_roll[15], chassis_roll};
		pmag = pe[16] ? 17'(-pe) : 17'(pe);
		rmag = re[16] ? 17'(-re) : 17'(re);
	end

	// stage 2: yaw sum into one turn, encoder to angle
	always_comb begin
		ye = {{2{ysum_s1[16]}}, ysum_s1};
		if (ysum_s1 >= CD_TURN17) begin
			yred = ye - CD_TURN;
		end else if (!ysum_s1[16]) begin
			yred = ye;
		end else if (ysum_s1 >= -CD_TURN17) begin
			yred = ye + CD_TURN;
		end else begin
			yred = ye + (CD_TURN <<< 1);
		end
		ep = EP_W'(enc_s1) * EP_W'(36000);
	end

	// stage 3: difference and wrap into [-half, half)
	always_comb begin
		z33 = $signed({1'b0, a_s2}) - $signed({1'b0, sr_s2, 16'b0});
		if (z33 >= HALF33) begin
			zwr = z33 - TURN33;
		end else if (z33 < -HALF33) begin
			zwr = z33 + TURN33;
		end else begin
			zwr = z33;
		end
	end

	// stage 4: fold into the right half plane, sign flipped afterwards
	always_comb begin
		if (zw_s3 > gptc_pkg::QUARTER_TURN) begin
			zf = zw_s3 - gptc_pkg::HALF_TURN;
			nf = 1'b1;
		end else if (zw_s3 < -gptc_pkg::QUARTER_TURN) begin
			zf = zw_s3 + gptc_pkg::HALF_TURN;
			nf = 1'b1;
		end else begin
			zf = zw_s3;
			nf = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_v;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_v) begin
			pitch_s1 <= (pmag < {3'b0, dead_zone}) ? 16'sd0 : chassis_pitch;
			roll_s1  <= (rmag < {3'b0, dead_zone}) ? 16'sd0 : chassis_roll;
			ysum_s1  <= {chassis_yaw[15], chassis_yaw} + {yaw_offset[15], yaw_offset};
			enc_s1   <= yaw_encoder;
		end
		if (rdy2 && v_s1) begin
			sr_s2    <= yred[15:0];
			a_s2     <= 32'(ep) << SH;
			pitch_s2 <= pitch_s1;
			roll_s2  <= roll_s1;
		end
		if (rdy3 && v_s2) begin
			zw_s3    <= zwr[31:0];
			pitch_s3 <= pitch_s2;
			roll_s3  <= roll_s2;
		end
		if (rdy4 && v_s3) begin
			z_s4     <= zf;
			neg_s4   <= nf;
			pitch_s4 <= pitch_s3;
			roll_s4  <= roll_s3;
		end
	end

	assign dn_v     = v_s4;
	assign dn_z     = z_s4;
	assign dn_neg   = neg_s4;
	assign dn_pitch = pitch_s4;
	assign dn_roll  = roll_s4;

endmodule
`default_nettype wire

// ===== hw/rtl/gptc_cell.sv =====
// one cordic rotation cell of the chain
`default_nettype none
module gptc_cell #(
	parameter int STAGE = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_v,
	output logic                   up_rdy,
	input  wire gptc_pkg::cordic_t up_d,
	output logic                   dn_v,
	input  wire logic              dn_rdy,
	output gptc_pkg::cordic_t      dn_d
);

	logic v_q;
	gptc_pkg::cordic_t d_q, nx;
	logic signed [gptc_pkg::XY_W-1:0] dx, dy;
	logic signed [gptc_pkg::Z_W-1:0] ang;

	assign up_rdy = !v_q || dn_rdy;

	always_comb begin
		dx  = up_d.y >>> STAGE;
		dy  = up_d.x >>> STAGE;
		ang = gptc_pkg::atan_q16(STAGE);
		nx  = up_d;
		// z >= 0 rotates positive
		if (!up_d.z[gptc_pkg::Z_W-1]) begin
			nx.x = up_d.x - dx;
			nx.y = up_d.y + dy;
			nx.z = up_d.z - ang;
		end else begin
			nx.x = up_d.x + dx;
			nx.y = up_d.y - dy;
			nx.z = up_d.z + ang;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (up_rdy) begin
			v_q <= up_v;
		end
	end

	always_ff @(posedge clk) begin
		if (up_rdy && up_v) begin
			d_q <= nx;
		end
	end

	assign dn_v = v_q;
	assign dn_d = d_q;

endmodule
`default_nettype wire

// ===== hw/rtl/gptc_post.sv =====
// back end: q1.15 rounding, weighted sum, scale by 1/72000 and output register
`default_nettype none
module gptc_post (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              up_v,
	output logic                   up_rdy,
	input  wire gptc_pkg::cordic_t up_d,
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic signed [15:0]     pitch_corr
);

	// floor(m / 1125) = (m * RECIP) >> 36 exactly for m below 2^26
	localparam logic [25:0] RECIP = 26'd61083980;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	logic signed [15:0] c_s1, s_s1, pitch_s1, roll_s1;
	logic signed [31:0] pp_s2, pr_s2;
	logic signed [32:0] sum_s3;
	logic [25:0] m_s4;
	logic sgn_s4, sgn_s5;
	logic [51:0] prod_s5;
	logic signed [15:0] res_s6;

	logic signed [15:0] cq, sq;
	logic [32:0] amag;
	logic [15:0] quo;
	logic signed [16:0] sres;

	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v, input logic neg);
		logic signed [17:0] r;
		logic signed [18:0] rn;
		r  = 18'((v + 33'sd16384) >>> 15);
		rn = neg ? -{r[17], r} : {r[17], r};
		if (rn > 19'sd32767) return 16'sd32767;
		else if (rn < -19'sd32768) return -16'sd32768;
		else return rn[15:0];
	endfunction

	assign rdy6 = !v_s6 || !out_stall;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign up_rdy = rdy1;

	always_comb begin
		cq   = to_q15(up_d.x, up_d.neg);
		sq   = to_q15(up_d.y, up_d.neg);
		amag = sum_s3[32] ? 33'(-sum_s3) : 33'(sum_s3);
		quo  = prod_s5[51:36];
		sres = sgn_s5 ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= up_v;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && up_v) begin
			c_s1     <= cq;
			s_s1     <= sq;
			pitch_s1 <= up_d.pitch;
			roll_s1  <= up_d.roll;
		end
		if (rdy2 && v_s1) begin
			pp_s2 <= pitch_s1 * c_s1;
			pr_s2 <= roll_s1 * s_s1;
		end
		if (rdy3 && v_s2) begin
			sum_s3 <= {pp_s2[31], pp_s2} + {pr_s2[31], pr_s2};
		end
		if (rdy4 && v_s3) begin
			// 72000 = 64 * 1125, the low six bits drop out first
			m_s4   <= amag[31:6];
			sgn_s4 <= sum_s3[32];
		end
		if (rdy5 && v_s4) begin
			prod_s5 <= 52'(m_s4) * 52'(RECIP);
			sgn_s5  <= sgn_s4;
		end
		if (rdy6 && v_s5) begin
			if (sres > 17'sd32767) res_s6 <= 16'sd32767;
			else if (sres < -17'sd32768) res_s6 <= -16'sd32768;
			else res_s6 <= sres[15:0];
		end
	end

	assign out_valid = v_s6;
	assign pitch_corr = res_s6;

endmodule
`default_nettype wire

// ===== hw/rtl/gimbal_pitch_tilt_compensation.sv =====
// top level: config registers, front end, cordic cell chain and back end
// path from accept to out_valid: front end stages, CORDIC_STAGES cordic cells (at most 24), back end stages
// throughput: one transaction per cycle while out_stall is low; every stage holds one item and hands it on
// stages only stall when the item ahead is held, so bubbles are squeezed out under stall
// reset: all stage valid bits clear, yaw offset returns to 3800 and dead zone to 120
// config writes take effect on the next accepted transaction
`default_nettype none
module gimbal_pitch_tilt_compensation #(
	parameter int CORDIC_STAGES = 16,
	parameter int ENCODER_BITS  = 13
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_stall,
	input  wire logic signed [15:0]      chassis_pitch,
	input  wire logic signed [15:0]      chassis_roll,
	input  wire logic signed [15:0]      chassis_yaw,
	input  wire logic [ENCODER_BITS-1:0] yaw_encoder,
	output logic                         out_valid,
	input  wire logic                    out_stall,
	output logic signed [15:0]           pitch_corr,
	input  wire logic                    cfg_we,
	input  wire logic [0:0]              cfg_index,
	input  wire logic [15:0]             cfg_data
);

	localparam int NCELL = (CORDIC_STAGES < gptc_pkg::ATAN_ENTRIES) ?
		CORDIC_STAGES : gptc_pkg::ATAN_ENTRIES;

	logic signed [15:0] yaw_offset_q;
	logic [13:0] dead_zone_q;

	logic prep_rdy, prep_v, prep_neg;
	logic signed [gptc_pkg::Z_W-1:0] prep_z;
	logic signed [15:0] prep_pitch, prep_roll;

	logic cv [0:NCELL];
	logic crdy [0:NCELL];
	gptc_pkg::cordic_t cd [0:NCELL];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			yaw_offset_q <= 16'sd3800;
			dead_zone_q  <= 14'd120;
		end else if (cfg_we) begin
			case (cfg_index)
				gptc_pkg::REG_YAW_OFFSET: yaw_offset_q <= cfg_data;
				gptc_pkg::REG_DEAD_ZONE:  dead_zone_q  <= cfg_data[13:0];
				default: ;
			endcase
		end
	end

	gptc_prep #(
		.ENCODER_BITS(ENCODER_BITS)
	) u_prep (
		.clk          (clk),
		.arst_n       (arst_n),
		.up_v         (in_valid),
		.up_rdy       (prep_rdy),
		.chassis_pitch(chassis_pitch),
		.chassis_roll (chassis_roll),
		.chassis_yaw  (chassis_yaw),
		.yaw_encoder  (yaw_encoder),
		.yaw_offset   (yaw_offset_q),
		.dead_zone    (dead_zone_q),
		.dn_v         (prep_v),
		.dn_rdy       (crdy[0]),
		.dn_z         (prep_z),
		.dn_neg       (prep_neg),
		.dn_pitch     (prep_pitch),
		.dn_roll      (prep_roll)
	);

	assign in_stall = !prep_rdy;

	always_comb begin
		cv[0]       = prep_v;
		cd[0].x     = gptc_pkg::CORDIC_GAIN;
		cd[0].y     = '0;
		cd[0].z     = prep_z;
		cd[0].neg   = prep_neg;
		cd[0].pitch = prep_pitch;
		cd[0].roll  = prep_roll;
	end

	for (genvar g = 0; g < NCELL; g++) begin : g_cell
		gptc_cell #(
			.STAGE(g)
		) u_cell (
			.clk   (clk),
			.arst_n(arst_n),
			.up_v  (cv[g]),
			.up_rdy(crdy[g]),
			.up_d  (cd[g]),
			.dn_v  (cv[g+1]),
			.dn_rdy(crdy[g+1]),
			.dn_d  (cd[g+1])
		);
	end

	gptc_post u_post (
		.clk       (clk),
		.arst_n    (arst_n),
		.up_v      (cv[NCELL]),
		.up_rdy    (crdy[NCELL]),
		.up_d      (cd[NCELL]),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.pitch_corr(pitch_corr)
	);

	// an empty output slot means the whole chain can move
	a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> !in_stall)
		else $error("input stalled with empty output register");

	a_dead_zone_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == gptc_pkg::REG_DEAD_ZONE |=> dead_zone_q == $past(cfg_data[13:0]))
		else $error("dead zone write lost");

	a_offset_write: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && cfg_index == gptc_pkg::REG_YAW_OFFSET |=> yaw_offset_q == $past(cfg_data))
		else $error("yaw offset write lost");

endmodule
`default_nettype wire
